[hdl/rttr_pkg.sv]
package rttr_pkg;

    localparam int COORD_W = 32;
    localparam int SIZE_W  = COORD_W - 1;
    localparam int IDX_W   = 32;
    localparam int CNT_W   = 32;
    // edge - origin needs 34 bits; two spare
    localparam int NUM_W   = COORD_W + 4;
    localparam int MAG_W   = NUM_W - 1;
    // divider: load stage, one stage per quotient bit, floor stage
    localparam int DIV_LAT = MAG_W + 2;

    typedef enum logic [2:0] {
        CFG_ORIGIN_X   = 3'd0,
        CFG_ORIGIN_Y   = 3'd1,
        CFG_TILE_W     = 3'd2,
        CFG_TILE_H     = 3'd3,
        CFG_BOUND_MODE = 3'd4,
        CFG_MAX_CAND   = 3'd5
    } t_cfg_idx;

endpackage

[hdl/rttr_div.sv]
module rttr_div (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic signed [rttr_pkg::NUM_W-1:0]   i_num,
    input  logic        [rttr_pkg::SIZE_W-1:0]  i_den,
    output logic signed [rttr_pkg::NUM_W-1:0]   o_quo
);
    import rttr_pkg::*;

    logic [MAG_W-1:0]  r_mag [MAG_W+1];
    logic [MAG_W-1:0]  r_quo [MAG_W+1];
    logic [SIZE_W-1:0] r_rem [MAG_W+1];
    logic              r_neg [MAG_W+1];
    logic [NUM_W-1:0]  abs_num;
    logic [NUM_W-1:0]  n_quo;
    logic [NUM_W-1:0]  r_quo_out;

    assign abs_num = i_num[NUM_W-1] ? (~i_num + 1'b1) : i_num;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg[0] <= i_num[NUM_W-1];
            r_mag[0] <= abs_num[MAG_W-1:0];
            r_rem[0] <= '0;
            r_quo[0] <= '0;
        end
    end

    // restoring division, one quotient bit per stage, msb first
    for (genvar k = 0; k < MAG_W; k++) begin : g_stage
        logic [SIZE_W:0] trial;
        logic [SIZE_W:0] diff;
        logic            ge;
        always_comb begin
            trial = {r_rem[k], r_mag[k][MAG_W-1]};
            diff  = trial - {1'b0, i_den};
            ge    = trial >= {1'b0, i_den};
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_neg[k+1] <= r_neg[k];
                r_mag[k+1] <= {r_mag[k][MAG_W-2:0], 1'b0};
                r_rem[k+1] <= ge ? diff[SIZE_W-1:0] : trial[SIZE_W-1:0];
                r_quo[k+1] <= {r_quo[k][MAG_W-2:0], ge};
            end
        end
    end

    // floor for negative numerators: -q, or -q-1 when a remainder is left
    always_comb begin
        if (!r_neg[MAG_W]) begin
            n_quo = {1'b0, r_quo[MAG_W]};
        end else if (r_rem[MAG_W] != '0) begin
            n_quo = ~{1'b0, r_quo[MAG_W]};
        end else begin
            n_quo = ~{1'b0, r_quo[MAG_W]} + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_quo_out <= n_quo;
        end
    end

    assign o_quo = r_quo_out;

endmodule

[hdl/rect_to_tile_range_unit.sv]
// channel  | dir | tdata (low bit up)                                  | tuser
// s_axis   | in  | rect_x, rect_y, rect_w, rect_h (4 x 32)             | -
// m_axis   | out | first_col, first_row, last_col, last_row, tile_count | range_valid
// cfg      | in  | index 3 bits, data 32 bits, always ready             | -
//
// One rectangle per cycle while m_axis is not stalled; the path runs through the edge
// stage, the 37 stages of each of the four bit-serial pipelined dividers, and index
// check, span check, multiply and limit stages.
// Reset (i_rst_n low, synchronous) empties the pipe and loads register defaults.
// A stall on m_axis freezes every stage; s_axis_tready follows it.
module rect_to_tile_range_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,   // rect_x, rect_y, rect_w, rect_h
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [159:0] m_axis_tdata,   // first_col, first_row, last_col, last_row, tile_count
    output logic         m_axis_tuser,   // range_valid
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [2:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_data
);
    import rttr_pkg::*;

    logic signed [COORD_W-1:0] r_org_x, r_org_y;
    logic [SIZE_W-1:0]         r_tile_w, r_tile_h;
    logic                      r_mode;
    logic [CNT_W-1:0]          r_max;

    logic en;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org_x  <= '0;
            r_org_y  <= '0;
            r_tile_w <= SIZE_W'(65536);
            r_tile_h <= SIZE_W'(65536);
            r_mode   <= 1'b0;
            r_max    <= CNT_W'(1024);
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_ORIGIN_X:   r_org_x  <= i_cfg_data;
                CFG_ORIGIN_Y:   r_org_y  <= i_cfg_data;
                CFG_TILE_W:     r_tile_w <= i_cfg_data[SIZE_W-1:0];
                CFG_TILE_H:     r_tile_h <= i_cfg_data[SIZE_W-1:0];
                CFG_BOUND_MODE: r_mode   <= i_cfg_data[0];
                CFG_MAX_CAND:   r_max    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    // edge stage
    logic signed [NUM_W-1:0] x, y, w, h, ox, oy, adj0, adj1;
    logic signed [NUM_W-1:0] r_nx0, r_ny0, r_nx1, r_ny1;
    logic                    r_a_v, r_a_bad;

    always_comb begin
        x    = NUM_W'(signed'(s_axis_tdata[31:0]));
        y    = NUM_W'(signed'(s_axis_tdata[63:32]));
        w    = NUM_W'(signed'(s_axis_tdata[95:64]));
        h    = NUM_W'(signed'(s_axis_tdata[127:96]));
        ox   = NUM_W'(r_org_x);
        oy   = NUM_W'(r_org_y);
        adj0 = r_mode ? -NUM_W'(1) : NUM_W'(0);
        adj1 = r_mode ? NUM_W'(1) : -NUM_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else if (en) begin
            r_a_v <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_nx0   <= x + adj0 - ox;
            r_ny0   <= y + adj0 - oy;
            r_nx1   <= x + w + adj1 - ox;
            r_ny1   <= y + h + adj1 - oy;
            r_a_bad <= (w <= 0) || (h <= 0) || (r_tile_w == '0) || (r_tile_h == '0)
                       || (r_max == '0);
        end
    end

    logic signed [NUM_W-1:0] qc0, qr0, qc1, qr1;

    rttr_div u_div_c0 (.i_clk, .i_en(en), .i_num(r_nx0), .i_den(r_tile_w), .o_quo(qc0));
    rttr_div u_div_r0 (.i_clk, .i_en(en), .i_num(r_ny0), .i_den(r_tile_h), .o_quo(qr0));
    rttr_div u_div_c1 (.i_clk, .i_en(en), .i_num(r_nx1), .i_den(r_tile_w), .o_quo(qc1));
    rttr_div u_div_r1 (.i_clk, .i_en(en), .i_num(r_ny1), .i_den(r_tile_h), .o_quo(qr1));

    // sideband alongside the dividers
    logic r_sb_v   [DIV_LAT];
    logic r_sb_bad [DIV_LAT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DIV_LAT; i++) r_sb_v[i] <= 1'b0;
        end else if (en) begin
            r_sb_v[0] <= r_a_v;
            for (int i = 1; i < DIV_LAT; i++) r_sb_v[i] <= r_sb_v[i-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sb_bad[0] <= r_a_bad;
            for (int i = 1; i < DIV_LAT; i++) r_sb_bad[i] <= r_sb_bad[i-1];
        end
    end

    // index check: every index must fit signed 32 bits
    function automatic logic fits(input logic signed [NUM_W-1:0] q);
        logic [NUM_W-IDX_W:0] top;
        top = q[NUM_W-1:IDX_W-1];
        return (top == '0) || (top == '1);
    endfunction

    logic signed [IDX_W-1:0] r_c0, r_r0, r_c1, r_r1;
    logic                    r_b_v, r_b_bad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
        end else if (en) begin
            r_b_v <= r_sb_v[DIV_LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c0    <= qc0[IDX_W-1:0];
            r_r0    <= qr0[IDX_W-1:0];
            r_c1    <= qc1[IDX_W-1:0];
            r_r1    <= qr1[IDX_W-1:0];
            r_b_bad <= r_sb_bad[DIV_LAT-1] || !fits(qc0) || !fits(qr0) || !fits(qc1)
                       || !fits(qr1);
        end
    end

    // span stage
    logic [IDX_W:0] cols, rows;
    logic [CNT_W-1:0] r_cols, r_rows;
    logic signed [IDX_W-1:0] r_oc0, r_or0, r_oc1, r_or1, r_pc0, r_pr0, r_pc1, r_pr1;
    logic r_c_v, r_c_bad;

    always_comb begin
        cols = {r_c1[IDX_W-1], r_c1} - {r_c0[IDX_W-1], r_c0} + 1'b1;
        rows = {r_r1[IDX_W-1], r_r1} - {r_r0[IDX_W-1], r_r0} + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_v <= 1'b0;
        end else if (en) begin
            r_c_v <= r_b_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cols  <= cols[CNT_W-1:0];
            r_rows  <= rows[CNT_W-1:0];
            r_oc0   <= r_c0;
            r_or0   <= r_r0;
            r_oc1   <= r_c1;
            r_or1   <= r_r1;
            r_c_bad <= r_b_bad || (r_c0 > r_c1) || (r_r0 > r_r1)
                       || (cols > {1'b0, r_max}) || (rows > {1'b0, r_max});
        end
    end

    // multiply stage
    logic [2*CNT_W-1:0] r_prod;
    logic               r_d_v, r_d_bad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_v <= 1'b0;
        end else if (en) begin
            r_d_v <= r_c_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_prod  <= r_cols * r_rows;
            r_pc0   <= r_oc0;
            r_pr0   <= r_or0;
            r_pc1   <= r_oc1;
            r_pr1   <= r_or1;
            r_d_bad <= r_c_bad;
        end
    end

    // limit stage and output word
    logic       ok;
    logic [159:0] r_out_data;
    logic         r_out_ok;
    logic         r_out_v;

    assign ok = !r_d_bad && (r_prod <= {{CNT_W{1'b0}}, r_max});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en) begin
            r_out_v <= r_d_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_ok   <= ok;
            r_out_data <= ok ? {r_prod[CNT_W-1:0], r_pr1, r_pc1, r_pr0, r_pc0} : '0;
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_ok;

endmodule

[hdl/rttr_checker.sv]
module rttr_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [159:0] m_axis_tdata,
    input logic         m_axis_tuser
);

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
        else $error("invalid word carries non-zero fields");

    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[159:128] != '0)
        else $error("valid range with zero tile count");

    a_col_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |->
            $signed(m_axis_tdata[31:0]) <= $signed(m_axis_tdata[95:64]))
        else $error("first column above last column");

    a_stall_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("input taken while output stalled");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled output word changed");

endmodule

bind rect_to_tile_range_unit rttr_checker u_rttr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
